/* hdl/lbq_pkg.sv */
// package for the linked block byte queue manager
// types, sizes and codes shared by controller, datapath and top level
package lbq_pkg;
  localparam int NUM_QUEUES  = 32;
  localparam int NUM_BLOCKS  = 32;
  localparam int BLOCK_BYTES = 40;
  localparam int QW = $clog2(NUM_QUEUES);
  localparam int BW = $clog2(NUM_BLOCKS);
  localparam int OW = 6;
  localparam int AW = $clog2(NUM_BLOCKS * BLOCK_BYTES);
  localparam logic [7:0] ERR_BYTE = 8'd255;

  typedef enum logic [1:0] {
    MODE_CREATE  = 2'd0,
    MODE_DESTROY = 2'd1,
    MODE_ENQ     = 2'd2,
    MODE_DEQ     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_ILLEGAL = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [4:0] queue_sel;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] new_queue;
    logic [7:0] out_byte;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_WALK,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic finish_read;
    logic walk_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_read;
    logic need_walk;
    logic walk_last;
  } stat_t;
endpackage

/* hdl/lbq_ctrl.sv */
// controller state machine for the queue manager
// uses lbq_pkg; drives the datapath by cmd_t, watches stat_t
module lbq_ctrl import lbq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  output cmd_t  cmd,
  input  stat_t stat
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: begin
        if (stat.need_read) state_next = S_READ;
        else if (stat.need_walk) state_next = S_WALK;
        else state_next = S_DONE;
      end
      S_READ: state_next = S_DONE;
      S_WALK: if (stat.walk_last) state_next = S_DONE;
      S_DONE: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != S_IDLE);
    out_valid = (state == S_DONE);
    cmd.load        = (state == S_IDLE) && in_valid;
    cmd.exec        = (state == S_EXEC);
    cmd.finish_read = (state == S_READ);
    cmd.walk_step   = (state == S_WALK);
  end

  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid) else $error("result repeated");
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_walk_exit: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk_step && stat.walk_last) |=> out_valid) else $error("walk did not end");
endmodule

/* hdl/lbq_dp.sv */
// datapath: queue tables, block flags, link table and byte memory
// uses lbq_pkg; steered by cmd_t from lbq_ctrl
module lbq_dp import lbq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output stat_t     stat,
  output out_item_t res
);
  logic [7:0]    byte_store [NUM_BLOCKS*BLOCK_BYTES];
  logic [BW-1:0] next_block [NUM_BLOCKS];
  logic [BW-1:0] head_block [NUM_QUEUES];
  logic [BW-1:0] last_block [NUM_QUEUES];
  logic [OW-1:0] read_offset [NUM_QUEUES];
  logic [OW-1:0] write_offset [NUM_QUEUES];
  logic [NUM_BLOCKS-1:0] block_used;
  logic [NUM_QUEUES-1:0] slot_used, slot_has_block;

  in_item_t      cur;
  logic [7:0]    rd_data;
  logic [BW-1:0] walk_blk, walk_end;
  logic          pend_read, pend_walk;

  logic [QW-1:0] q;
  logic [QW-1:0] free_slot;
  logic [BW-1:0] free_blk;
  logic          slot_any, blk_any;

  assign q = cur.queue_sel[QW-1:0];

  // lowest-index free search, priority encoders
  always_comb begin
    free_slot = '0;
    slot_any  = 1'b0;
    for (int i = NUM_QUEUES-1; i >= 0; i--)
      if (!slot_used[i]) begin
        free_slot = QW'(i);
        slot_any  = 1'b1;
      end
    free_blk = '0;
    blk_any  = 1'b0;
    for (int i = NUM_BLOCKS-1; i >= 0; i--)
      if (!block_used[i]) begin
        free_blk = BW'(i);
        blk_any  = 1'b1;
      end
  end

  logic          sel_ok, has_blk, sole, wr_full;
  logic [BW-1:0] fb, lb;
  logic [OW-1:0] ro, wo;
  logic [AW-1:0] wr_addr, rd_addr;

  always_comb begin
    sel_ok  = (32'(cur.queue_sel) < NUM_QUEUES) && slot_used[q];
    has_blk = slot_has_block[q];
    fb = head_block[q];
    lb = last_block[q];
    ro = read_offset[q];
    wo = write_offset[q];
    sole = (fb == lb);
    wr_full = (32'(wo) >= BLOCK_BYTES);
    wr_addr = AW'(32'(lb) * BLOCK_BYTES + 32'(wo));
    rd_addr = AW'(32'(fb) * BLOCK_BYTES + 32'(ro));
  end

  always_comb begin
    stat.need_read = cmd.exec && sel_ok && (cur.mode == MODE_DEQ) && has_blk &&
                     !(sole && ro >= wo);
    stat.need_walk = cmd.exec && sel_ok && (cur.mode == MODE_DESTROY) && has_blk;
    stat.walk_last = (walk_blk == walk_end);
  end

  // byte memory, at most one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.exec && cur.mode == MODE_ENQ && sel_ok) begin
      if (!has_blk || wr_full) begin
        if (blk_any) byte_store[AW'(32'(free_blk) * BLOCK_BYTES)] <= cur.in_byte;
      end else begin
        byte_store[wr_addr] <= cur.in_byte;
      end
    end
    rd_data <= byte_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) cur <= in_item;
    if (rst) begin
      block_used <= '0;
      slot_used <= '0;
      slot_has_block <= '0;
    end else if (cmd.exec) begin
      pend_read <= 1'b0;
      unique case (mode_t'(cur.mode))
        MODE_CREATE: begin
          res.new_queue <= '0;
          res.out_byte <= ERR_BYTE;
          res.status <= ST_OOM;
          if (slot_any && blk_any) begin
            slot_used[free_slot] <= 1'b1;
            slot_has_block[free_slot] <= 1'b1;
            block_used[free_blk] <= 1'b1;
            head_block[free_slot] <= free_blk;
            last_block[free_slot] <= free_blk;
            read_offset[free_slot] <= '0;
            write_offset[free_slot] <= '0;
            res.new_queue <= 5'(free_slot);
            res.out_byte <= 8'd0;
            res.status <= ST_OK;
          end
        end
        MODE_DESTROY: begin
          res.new_queue <= '0;
          if (!sel_ok) begin
            res.status <= ST_ILLEGAL;
            res.out_byte <= ERR_BYTE;
          end else begin
            res.status <= ST_OK;
            res.out_byte <= 8'd0;
            slot_used[q] <= 1'b0;
            slot_has_block[q] <= 1'b0;
            walk_blk <= fb;
            walk_end <= lb;
          end
        end
        MODE_ENQ: begin
          res.new_queue <= '0;
          res.status <= ST_OK;
          res.out_byte <= 8'd0;
          if (!sel_ok) begin
            res.status <= ST_ILLEGAL;
            res.out_byte <= ERR_BYTE;
          end else if (!has_blk || wr_full) begin
            if (!blk_any) begin
              res.status <= ST_OOM;
              res.out_byte <= ERR_BYTE;
            end else begin
              block_used[free_blk] <= 1'b1;
              if (has_blk) next_block[lb] <= free_blk;
              else begin
                head_block[q] <= free_blk;
                read_offset[q] <= '0;
                slot_has_block[q] <= 1'b1;
              end
              last_block[q] <= free_blk;
              write_offset[q] <= OW'(1);
            end
          end else begin
            write_offset[q] <= wo + OW'(1);
          end
        end
        MODE_DEQ: begin
          res.new_queue <= '0;
          if (stat.need_read) begin
            res.status <= ST_OK;
            pend_read <= 1'b1;
            if (32'(ro) + 1 >= BLOCK_BYTES) begin
              block_used[fb] <= 1'b0;
              read_offset[q] <= '0;
              if (sole) begin
                slot_has_block[q] <= 1'b0;
                write_offset[q] <= '0;
              end else begin
                head_block[q] <= next_block[fb];
              end
            end else begin
              read_offset[q] <= ro + OW'(1);
            end
          end else begin
            res.status <= ST_ILLEGAL;
            res.out_byte <= ERR_BYTE;
          end
        end
        default: ;
      endcase
    end else if (cmd.finish_read) begin
      res.out_byte <= rd_data;
    end else if (cmd.walk_step) begin
      // one chain link per cycle
      block_used[walk_blk] <= 1'b0;
      walk_blk <= next_block[walk_blk];
    end
    pend_walk <= stat.need_walk;
  end

  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.finish_read |-> pend_read) else $error("read without dequeue");
  a_walk_from_destroy: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk_step && $past(cmd.exec)) |-> pend_walk) else $error("walk without destroy");
  a_create_marks: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && cur.mode == MODE_CREATE && slot_any && blk_any) |=>
    block_used[$past(free_blk)]) else $error("create lost block");
endmodule

/* hdl/linked_block_byte_queue_manager.sv */
// top level of the linked block byte queue manager
// uses lbq_pkg; joins lbq_ctrl and lbq_dp
//
// channel  dir  handshake          payload
// in       in   in_valid/in_stall  in_item_t  (mode, queue_sel, in_byte)
// out      out  out_valid/out_stall out_item_t (status, new_queue, out_byte)
//
// create, enqueue, a failed dequeue and a destroy that frees no block go from S_EXEC
// straight to S_DONE for the result beat, a dequeue that reads passes through S_READ
// (registered byte memory read), and destroy walks the chain in S_WALK, block by block.
// one item at a time; in_stall stays high until the result beat is taken.
// synchronous reset clears the state machine and all flag vectors at once.
module linked_block_byte_queue_manager import lbq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);
  cmd_t  cmd;
  stat_t stat;

  lbq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat)
  );

  lbq_dp u_dp (
    .clk(clk), .rst(rst), .in_item(in_item), .cmd(cmd), .stat(stat), .res(out_item)
  );
endmodule

/* tb/sv/testbench.sv */
// testbench for the linked block byte queue manager
// uses lbq_pkg and the top level linked_block_byte_queue_manager; the queue
// model below keeps its own block chains and predicts every result beat
module testbench;
  import lbq_pkg::*;

  class queue_scoreboard;
    // model state
    logic [7:0] store [NUM_BLOCKS*BLOCK_BYTES];
    logic [4:0] link [NUM_BLOCKS];
    bit blk_busy [NUM_BLOCKS];
    bit slot_busy [NUM_QUEUES];
    bit slot_blk [NUM_QUEUES];
    logic [4:0] head_blk [NUM_QUEUES];
    logic [4:0] tail_blk [NUM_QUEUES];
    int rd_pos [NUM_QUEUES];
    int wr_pos [NUM_QUEUES];
    out_item_t pending [$];
    int errors;
    int results_seen;
    int n_oom;
    int n_illegal;

    function void clear();
      for (int i = 0; i < NUM_BLOCKS; i++) blk_busy[i] = 0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        slot_busy[i] = 0;
        slot_blk[i] = 0;
      end
    endfunction

    function int lowest_free_block();
      for (int i = 0; i < NUM_BLOCKS; i++)
        if (!blk_busy[i]) return i;
      return NUM_BLOCKS;
    endfunction

    // predict the result of one accepted command and queue it
    function void note_command(in_item_t it);
      out_item_t r;
      int q, s, b, cur, h, rp;
      bit sole;
      r.status = ST_OK;
      r.new_queue = '0;
      r.out_byte = 8'd0;
      q = it.queue_sel;
      if (it.mode == MODE_CREATE) begin
        for (s = 0; s < NUM_QUEUES; s++)
          if (!slot_busy[s]) break;
        b = lowest_free_block();
        if (s >= NUM_QUEUES || b >= NUM_BLOCKS) r.status = ST_OOM;
        else begin
          slot_busy[s] = 1;
          slot_blk[s] = 1;
          blk_busy[b] = 1;
          head_blk[s] = 5'(b);
          tail_blk[s] = 5'(b);
          rd_pos[s] = 0;
          wr_pos[s] = 0;
          r.new_queue = 5'(s);
        end
      end else if (q >= NUM_QUEUES || !slot_busy[q]) begin
        r.status = ST_ILLEGAL;
      end else if (it.mode == MODE_DESTROY) begin
        if (slot_blk[q]) begin
          cur = head_blk[q];
          for (int n = 0; n < NUM_BLOCKS; n++) begin
            blk_busy[cur] = 0;
            if (cur == tail_blk[q]) break;
            cur = link[cur];
          end
        end
        slot_busy[q] = 0;
        slot_blk[q] = 0;
      end else if (it.mode == MODE_ENQ) begin
        if (!slot_blk[q] || wr_pos[q] >= BLOCK_BYTES) begin
          b = lowest_free_block();
          if (b >= NUM_BLOCKS) r.status = ST_OOM;
          else begin
            blk_busy[b] = 1;
            store[b*BLOCK_BYTES] = it.in_byte;
            if (slot_blk[q]) link[tail_blk[q]] = 5'(b);
            else begin
              head_blk[q] = 5'(b);
              rd_pos[q] = 0;
              slot_blk[q] = 1;
            end
            tail_blk[q] = 5'(b);
            wr_pos[q] = 1;
          end
        end else begin
          store[tail_blk[q]*BLOCK_BYTES + wr_pos[q]] = it.in_byte;
          wr_pos[q]++;
        end
      end else begin
        if (!slot_blk[q]) r.status = ST_ILLEGAL;
        else begin
          h = head_blk[q];
          rp = rd_pos[q];
          sole = (head_blk[q] == tail_blk[q]);
          if (sole && rp >= wr_pos[q]) r.status = ST_ILLEGAL;
          else begin
            r.out_byte = store[h*BLOCK_BYTES + rp];
            if (rp + 1 >= BLOCK_BYTES) begin
              blk_busy[h] = 0;
              rd_pos[q] = 0;
              if (sole) begin
                slot_blk[q] = 0;
                wr_pos[q] = 0;
              end else head_blk[q] = link[h];
            end else rd_pos[q] = rp + 1;
          end
        end
      end
      if (r.status != ST_OK) r.out_byte = ERR_BYTE;
      if (r.status == ST_OOM) n_oom++;
      if (r.status == ST_ILLEGAL) n_illegal++;
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      results_seen++;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status);
        errors++;
      end
      if (got.new_queue !== exp_r.new_queue) begin
        $error("new_queue: expected %0d, got %0d", exp_r.new_queue, got.new_queue);
        errors++;
      end
      if (got.out_byte !== exp_r.out_byte) begin
        $error("out_byte: expected %0d, got %0d", exp_r.out_byte, got.out_byte);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG = 20000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_item;

  queue_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;
  int sent = 0;
  bit done = 0;
  // slots the stimulus believes are live, for well-formed commands
  int live [$];

  linked_block_byte_queue_manager u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
    .out_item(out_item)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // sample handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_command(in_item);
      if (out_valid && !out_stall) sb.check_result(out_item);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG && !done) begin
        $display("watchdog: no beat for %0d cycles", WATCHDOG);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver stall, changed at the falling edge
  always @(negedge clk)
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);

  // called at a falling edge; returns at the falling edge after the beat,
  // with in_valid still high so the next beat can follow without a gap
  task automatic send_command(logic [1:0] m, logic [4:0] q, logic [7:0] b);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      do @(negedge clk);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct);
    end
    in_item <= '{mode: m, queue_sel: q, in_byte: b};
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // track live slots from the model so random commands stay mostly legal
  task automatic refresh_live();
    live.delete();
    for (int i = 0; i < NUM_QUEUES; i++)
      if (sb.slot_busy[i]) live.push_back(i);
  endtask

  task automatic random_phase(int count);
    int pick, q;
    for (int i = 0; i < count; i++) begin
      refresh_live();
      pick = $urandom_range(99);
      q = live.size() ? live[$urandom_range(live.size() - 1)] : $urandom_range(31);
      if (pick < 3) q = $urandom_range(31);
      if (live.size() < 3 || pick < 6)
        send_command(MODE_CREATE, 5'($urandom), 8'($urandom));
      else if (pick < 9) send_command(MODE_DESTROY, 5'(q), 8'($urandom));
      else if (pick < 55) send_command(MODE_ENQ, 5'(q), 8'($urandom));
      else send_command(MODE_DEQ, 5'(q), 8'($urandom));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: unused slot, create, empty dequeue, byte extremes, dequeue past
    // the end, repeated destroy of one slot and destroy of a one-block queue
    send_command(MODE_DEQ, 5'd31, 8'd0);
    send_command(MODE_ENQ, 5'd0, 8'hff);
    send_command(MODE_DESTROY, 5'd0, 8'd0);
    send_command(MODE_CREATE, 5'd31, 8'hff);
    send_command(MODE_DEQ, 5'd0, 8'd0);
    send_command(MODE_ENQ, 5'd0, 8'h00);
    send_command(MODE_ENQ, 5'd0, 8'hff);
    send_command(MODE_DEQ, 5'd0, 8'd0);
    send_command(MODE_DEQ, 5'd0, 8'd0);
    send_command(MODE_DEQ, 5'd0, 8'd0);
    send_command(MODE_ENQ, 5'd0, 8'h5a);
    send_command(MODE_CREATE, 5'd0, 8'd0);
    send_command(MODE_DESTROY, 5'd1, 8'd0);
    send_command(MODE_DESTROY, 5'd1, 8'd0);
    send_command(MODE_DESTROY, 5'd0, 8'd0);
    drain();

    // fill a queue across blocks, drain it whole, refill, then destroy it
    send_command(MODE_CREATE, 5'd0, 8'd0);
    for (int i = 0; i < 2*BLOCK_BYTES + 3; i++) send_command(MODE_ENQ, 5'd0, 8'(i));
    for (int i = 0; i < 2*BLOCK_BYTES + 4; i++) send_command(MODE_DEQ, 5'd0, 8'd0);
    for (int i = 0; i < BLOCK_BYTES + 1; i++) send_command(MODE_ENQ, 5'd0, 8'hc3);
    send_command(MODE_DESTROY, 5'd0, 8'd0);
    // exhaust slots and blocks
    for (int i = 0; i < NUM_QUEUES + 2; i++) send_command(MODE_CREATE, 5'd0, 8'd0);
    send_command(MODE_ENQ, 5'd3, 8'h11);
    for (int i = 0; i < BLOCK_BYTES; i++) send_command(MODE_ENQ, 5'd7, 8'h22);
    send_command(MODE_DEQ, 5'd7, 8'd0);
    for (int i = 0; i < NUM_QUEUES; i++) send_command(MODE_DESTROY, 5'(i), 8'd0);
    drain();

    random_phase(300);
    drain();
    send_idle_pct = 81;
    random_phase(300);
    send_idle_pct = 0;
    recv_stall_pct = 81;
    random_phase(300);
    send_idle_pct = 37;
    recv_stall_pct = 37;
    random_phase(300);
    send_idle_pct = 0;
    recv_stall_pct = 0;

    drain();
    done = 1;
    $display("ran %0d commands, checked %0d results (%0d out of memory, %0d illegal)",
             sent, sb.results_seen, sb.n_oom, sb.n_illegal);
    $display("phases: no idling, sender gaps, receiver stalls, and both together");
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
